[design/upi_pkg.sv]
package upi_pkg;

    localparam int FRACTION_BITS = 16;

    localparam int ELAPSED_W = 20;
    localparam int WORD_W    = 32;
    localparam int TRIG_W    = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [WORD_W-1:0] DT_SCALE  = 32'd2251799814;
    localparam logic [WORD_W-1:0] RAD_SCALE = 32'd341782638;
    localparam int DT_FRAC    = 20;
    localparam int POS_SHIFT  = 46;
    localparam int HEAD_SHIFT = FRACTION_BITS + 31;

    localparam logic [WORD_W-1:0] SPEED_RESET = WORD_W'(1 << (FRACTION_BITS - 1));
    localparam logic [WORD_W-1:0] RATE_RESET  = WORD_W'(-(1 << (FRACTION_BITS - 1)));

    localparam int CORDIC_W     = 34;
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_W       = $clog2(CORDIC_STEPS);
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [CFG_IDX_W-1:0] CFG_LINEAR_SPEED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGULAR_RATE = 1'b1;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE      = 4'd0;
    localparam t_op OP_DT_MUL    = 4'd1;
    localparam t_op OP_DT_SET    = 4'd2;
    localparam t_op OP_ROT       = 4'd3;
    localparam t_op OP_TRIG_SAVE = 4'd4;
    localparam t_op OP_VEL_MUL   = 4'd5;
    localparam t_op OP_RATE_MUL  = 4'd6;
    localparam t_op OP_MAG_SAVE  = 4'd7;
    localparam t_op OP_MUL_LO    = 4'd8;
    localparam t_op OP_MUL_HI    = 4'd9;
    localparam t_op OP_ACC       = 4'd10;
    localparam t_op OP_POS_UPD   = 4'd11;
    localparam t_op OP_HEAD_UPD  = 4'd12;
    localparam t_op OP_PUB       = 4'd13;

    typedef logic [1:0] t_phase;
    localparam t_phase PH_X = 2'd0;
    localparam t_phase PH_Y = 2'd1;
    localparam t_phase PH_H = 2'd2;

    typedef struct packed {
        t_op               op;
        t_phase            phase;
        logic [ITER_W-1:0] iter;
    } t_cmd;

    typedef struct packed {
        logic out_hold;
    } t_status;

    function automatic logic signed [CORDIC_W-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            5'd0:    v = 34'sh20000000;
            5'd1:    v = 34'sh12E4051E;
            5'd2:    v = 34'sh09FB385B;
            5'd3:    v = 34'sh051111D4;
            5'd4:    v = 34'sh028B0D43;
            5'd5:    v = 34'sh0145D7E1;
            5'd6:    v = 34'sh00A2F61E;
            5'd7:    v = 34'sh00517C55;
            5'd8:    v = 34'sh0028BE53;
            5'd9:    v = 34'sh00145F2F;
            5'd10:   v = 34'sh000A2F98;
            5'd11:   v = 34'sh000517CC;
            5'd12:   v = 34'sh00028BE6;
            5'd13:   v = 34'sh000145F3;
            5'd14:   v = 34'sh0000A2FA;
            5'd15:   v = 34'sh0000517D;
            5'd16:   v = 34'sh000028BE;
            5'd17:   v = 34'sh0000145F;
            5'd18:   v = 34'sh00000A30;
            5'd19:   v = 34'sh00000518;
            5'd20:   v = 34'sh0000028C;
            5'd21:   v = 34'sh00000146;
            5'd22:   v = 34'sh000000A3;
            5'd23:   v = 34'sh00000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[design/upi_ctrl.sv]
module upi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  upi_pkg::t_status i_status,
    output upi_pkg::t_cmd    o_cmd
);
    import upi_pkg::*;

    localparam logic [3:0] ST_IDLE       = 4'd0;
    localparam logic [3:0] ST_DT_SET     = 4'd1;
    localparam logic [3:0] ST_ROT_MOTION = 4'd2;
    localparam logic [3:0] ST_TRIG       = 4'd3;
    localparam logic [3:0] ST_VEL        = 4'd4;
    localparam logic [3:0] ST_MAG        = 4'd5;
    localparam logic [3:0] ST_LO         = 4'd6;
    localparam logic [3:0] ST_HI         = 4'd7;
    localparam logic [3:0] ST_ACC        = 4'd8;
    localparam logic [3:0] ST_APPLY      = 4'd9;
    localparam logic [3:0] ST_ROT_QUAT   = 4'd10;
    localparam logic [3:0] ST_PUB        = 4'd11;

    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);

    logic [3:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    t_phase            r_phase, n_phase;

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_iter      = r_iter;
        n_phase     = r_phase;
        o_cmd.op    = OP_NONE;
        o_cmd.phase = r_phase;
        o_cmd.iter  = r_iter;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_DT_MUL;
                    n_state  = ST_DT_SET;
                end
            end
            ST_DT_SET: begin
                o_cmd.op = OP_DT_SET;
                n_iter   = '0;
                n_state  = ST_ROT_MOTION;
            end
            ST_ROT_MOTION: begin
                o_cmd.op = OP_ROT;
                if (r_iter == ITER_LAST) begin
                    n_iter  = '0;
                    n_state = ST_TRIG;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_TRIG: begin
                o_cmd.op = OP_TRIG_SAVE;
                n_phase  = PH_X;
                n_state  = ST_VEL;
            end
            ST_VEL: begin
                o_cmd.op = (r_phase == PH_H) ? OP_RATE_MUL : OP_VEL_MUL;
                n_state  = ST_MAG;
            end
            ST_MAG: begin
                o_cmd.op = OP_MAG_SAVE;
                n_state  = ST_LO;
            end
            ST_LO: begin
                o_cmd.op = OP_MUL_LO;
                n_state  = ST_HI;
            end
            ST_HI: begin
                o_cmd.op = OP_MUL_HI;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_state  = ST_APPLY;
            end
            ST_APPLY: begin
                if (r_phase == PH_H) begin
                    o_cmd.op = OP_HEAD_UPD;
                    n_iter   = '0;
                    n_state  = ST_ROT_QUAT;
                end else begin
                    o_cmd.op = OP_POS_UPD;
                    n_phase  = (r_phase == PH_X) ? PH_Y : PH_H;
                    n_state  = ST_VEL;
                end
            end
            ST_ROT_QUAT: begin
                o_cmd.op = OP_ROT;
                if (r_iter == ITER_LAST) begin
                    n_iter  = '0;
                    n_state = ST_PUB;
                end else begin
                    n_iter = r_iter + 1'b1;
                end
            end
            ST_PUB: begin
                if (!i_status.out_hold) begin
                    o_cmd.op = OP_PUB;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_iter  <= '0;
            r_phase <= PH_X;
        end else begin
            r_state <= n_state;
            r_iter  <= n_iter;
            r_phase <= n_phase;
        end
    end

endmodule

[design/upi_datapath.sv]
module upi_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  upi_pkg::t_cmd                          i_cmd,
    output upi_pkg::t_status                       o_status,
    input  logic [upi_pkg::ELAPSED_W-1:0]          i_elapsed_us,
    input  logic                                   i_cfg_wr_en,
    input  logic [upi_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [upi_pkg::WORD_W-1:0]             i_cfg_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [upi_pkg::WORD_W-1:0]      o_pos_x,
    output logic signed [upi_pkg::WORD_W-1:0]      o_pos_y,
    output logic [upi_pkg::WORD_W-1:0]             o_heading_angle,
    output logic signed [upi_pkg::TRIG_W-1:0]      o_quat_z,
    output logic signed [upi_pkg::TRIG_W-1:0]      o_quat_w
);
    import upi_pkg::*;

    localparam int SUM_W   = WORD_W + 4;
    localparam int DELTA_W = 35;

    function automatic logic signed [TRIG_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W:0]    t;
        logic signed [CORDIC_W-15:0] r;
        logic signed [TRIG_W-1:0]    q;
        t = {v[CORDIC_W-1], v} + 35'sd16384;
        r = t[CORDIC_W:15];
        if (r > 20'sd32767) begin
            q = 16'sh7FFF;
        end else if (r < -20'sd32768) begin
            q = 16'sh8000;
        end else begin
            q = r[TRIG_W-1:0];
        end
        return q;
    endfunction

    logic [WORD_W-1:0]          r_speed, r_rate;
    logic [WORD_W-1:0]          r_pos_x, r_pos_y, r_heading;
    logic [WORD_W-1:0]          r_dt;
    logic [2*WORD_W-1:0]        r_prod, r_mag;
    logic [3*WORD_W-1:0]        r_acc;
    logic                       r_neg;
    logic signed [TRIG_W-1:0]   r_sin, r_cos;
    logic signed [CORDIC_W-1:0] r_cx, r_cy, r_cz;
    logic                       r_flip;

    logic [WORD_W-1:0]          mul_a, mul_b, mul_k;
    logic [2*WORD_W-1:0]        n_prod;
    logic [WORD_W-1:0]          abs_speed, abs_rate;
    logic signed [TRIG_W-1:0]   trig_sel;
    logic [TRIG_W-1:0]          abs_trig;

    logic [WORD_W-1:0]          init_angle, init_fold;
    logic                       init_flip;
    logic [WORD_W-1:0]          n_heading, head_step;

    logic signed [CORDIC_W-1:0] x_sh, y_sh, fx, fy;

    logic [DELTA_W-2:0]         pos_mag;
    logic [DELTA_W-1:0]         pos_delta;
    logic [WORD_W-1:0]          pos_sel;
    logic [SUM_W-1:0]           pos_sum;
    logic [WORD_W-1:0]          pos_sat;

    assign abs_speed = r_speed[WORD_W-1] ? (~r_speed + 1'b1) : r_speed;
    assign abs_rate  = r_rate[WORD_W-1] ? (~r_rate + 1'b1) : r_rate;
    assign trig_sel  = (i_cmd.phase == PH_Y) ? r_sin : r_cos;
    assign abs_trig  = trig_sel[TRIG_W-1] ? TRIG_W'(-trig_sel) : trig_sel;
    assign mul_k     = (i_cmd.phase == PH_H) ? RAD_SCALE : r_dt;

    always_comb begin
        mul_a = r_mag[WORD_W-1:0];
        mul_b = mul_k;
        case (i_cmd.op)
            OP_DT_MUL: begin
                mul_a = WORD_W'(i_elapsed_us);
                mul_b = DT_SCALE;
            end
            OP_VEL_MUL: begin
                mul_a = abs_speed;
                mul_b = WORD_W'(abs_trig);
            end
            OP_RATE_MUL: begin
                mul_a = abs_rate;
                mul_b = r_dt;
            end
            OP_MUL_HI: begin
                mul_a = r_mag[2*WORD_W-1:WORD_W];
            end
            default: begin
                mul_a = r_mag[WORD_W-1:0];
            end
        endcase
    end

    assign n_prod = mul_a * mul_b;

    assign head_step = r_acc[HEAD_SHIFT+WORD_W-1:HEAD_SHIFT];
    assign n_heading = r_heading + (r_neg ? (~head_step + 1'b1) : head_step);

    assign init_angle = (i_cmd.op == OP_HEAD_UPD) ? n_heading : {r_heading[WORD_W-2:0], 1'b0};
    assign init_flip  = init_angle[WORD_W-1] ^ init_angle[WORD_W-2];
    assign init_fold  = {init_angle[WORD_W-1] ^ init_flip, init_angle[WORD_W-2:0]};

    assign x_sh = r_cx >>> i_cmd.iter;
    assign y_sh = r_cy >>> i_cmd.iter;
    assign fx   = r_flip ? -r_cx : r_cx;
    assign fy   = r_flip ? -r_cy : r_cy;

    assign pos_mag   = r_acc[POS_SHIFT+DELTA_W-2:POS_SHIFT];
    assign pos_delta = r_neg ? (~{1'b0, pos_mag} + 1'b1) : {1'b0, pos_mag};
    assign pos_sel   = (i_cmd.phase == PH_Y) ? r_pos_y : r_pos_x;
    assign pos_sum   = {{(SUM_W-WORD_W){pos_sel[WORD_W-1]}}, pos_sel}
                     + {pos_delta[DELTA_W-1], pos_delta};
    always_comb begin
        if (pos_sum[SUM_W-1:WORD_W-1] == '0 || pos_sum[SUM_W-1:WORD_W-1] == '1) begin
            pos_sat = pos_sum[WORD_W-1:0];
        end else if (pos_sum[SUM_W-1]) begin
            pos_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else begin
            pos_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    assign o_status.out_hold = o_out_valid && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= SPEED_RESET;
            r_rate      <= RATE_RESET;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_LINEAR_SPEED: r_speed <= i_cfg_data;
                    CFG_ANGULAR_RATE: r_rate  <= i_cfg_data;
                endcase
            end
            if (i_cmd.op == OP_POS_UPD) begin
                if (i_cmd.phase == PH_Y) begin
                    r_pos_y <= pos_sat;
                end else begin
                    r_pos_x <= pos_sat;
                end
            end
            if (i_cmd.op == OP_HEAD_UPD) begin
                r_heading <= n_heading;
            end
            if (i_cmd.op == OP_PUB) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op) inside
            OP_DT_MUL, OP_VEL_MUL, OP_RATE_MUL, OP_MUL_LO: begin
                r_prod <= n_prod;
                if (i_cmd.op == OP_VEL_MUL) begin
                    r_neg <= r_speed[WORD_W-1] ^ trig_sel[TRIG_W-1];
                end else if (i_cmd.op == OP_RATE_MUL) begin
                    r_neg <= r_rate[WORD_W-1];
                end
            end
            OP_MUL_HI: begin
                r_prod <= n_prod;
                r_acc  <= {{WORD_W{1'b0}}, r_prod};
            end
            OP_ACC: begin
                r_acc <= r_acc + {r_prod, {WORD_W{1'b0}}};
            end
            OP_MAG_SAVE: begin
                r_mag <= r_prod;
            end
            OP_DT_SET, OP_HEAD_UPD: begin
                if (i_cmd.op == OP_DT_SET) begin
                    r_dt <= r_prod[DT_FRAC+WORD_W-1:DT_FRAC];
                end
                r_cx   <= CORDIC_GAIN;
                r_cy   <= '0;
                r_cz   <= {{(CORDIC_W-WORD_W){init_fold[WORD_W-1]}}, init_fold};
                r_flip <= init_flip;
            end
            OP_ROT: begin
                if (!r_cz[CORDIC_W-1]) begin
                    r_cx <= r_cx - y_sh;
                    r_cy <= r_cy + x_sh;
                    r_cz <= r_cz - atan_step(i_cmd.iter);
                end else begin
                    r_cx <= r_cx + y_sh;
                    r_cy <= r_cy - x_sh;
                    r_cz <= r_cz + atan_step(i_cmd.iter);
                end
            end
            OP_TRIG_SAVE: begin
                r_sin <= to_q15(fy);
                r_cos <= to_q15(fx);
            end
            OP_PUB: begin
                o_pos_x         <= r_pos_x;
                o_pos_y         <= r_pos_y;
                o_heading_angle <= r_heading;
                o_quat_z        <= to_q15(fy);
                o_quat_w        <= to_q15(fx);
            end
            default: begin
            end
        endcase
    end

endmodule

[design/unicycle_pose_integrator.sv]
// A new input beat is accepted only in the idle state, once the previous result
// beat has been issued; issuing waits while an earlier result is held by a
// stalled output. Each beat uses two 24-step passes of the shared CORDIC unit
// and the shared 32x32 multiplier (three 2-partial-product terms).
// Reset (synchronous, active low) clears pose and output valid, loads defaults.
module unicycle_pose_integrator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  logic [upi_pkg::ELAPSED_W-1:0]          i_elapsed_us,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output logic signed [upi_pkg::WORD_W-1:0]      o_pos_x,
    output logic signed [upi_pkg::WORD_W-1:0]      o_pos_y,
    output logic [upi_pkg::WORD_W-1:0]             o_heading_angle,
    output logic signed [upi_pkg::TRIG_W-1:0]      o_quat_z,
    output logic signed [upi_pkg::TRIG_W-1:0]      o_quat_w,
    input  logic                                   i_cfg_wr_en,
    input  logic [upi_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [upi_pkg::WORD_W-1:0]             i_cfg_data
);
    import upi_pkg::*;

    t_cmd    cmd;
    t_status status;

    upi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    upi_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_elapsed_us    (i_elapsed_us),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pos_x         (o_pos_x),
        .o_pos_y         (o_pos_y),
        .o_heading_angle (o_heading_angle),
        .o_quat_z        (o_quat_z),
        .o_quat_w        (o_quat_w)
    );

endmodule

[tb/tb_unicycle_pose_integrator.sv]
module tb_unicycle_pose_integrator;
    timeunit 1ns;
    timeprecision 1ps;

    import upi_pkg::*;

    localparam int          FRAC        = 16;
    localparam logic [31:0] TICK_SCALE  = 32'd2251799814;
    localparam logic [31:0] ANGLE_SCALE = 32'd341782638;
    localparam longint      ROT_GAIN    = 652032874;
    localparam int          ROT_STEPS   = 24;
    localparam int          MOVE_SHIFT  = 46;
    localparam int          TURN_SHIFT  = FRAC + 31;
    localparam int          BEAT_CYCLES = 70;
    localparam int unsigned RUN_LIMIT   = 1000000;
    localparam int          REPORT_MAX  = 10;

    localparam logic [ROT_STEPS*32-1:0] ARCTAN = {
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        hdg;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } t_pose;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_stall;
    logic [ELAPSED_W-1:0]        elapsed_us = '0;
    logic                        out_valid;
    logic                        out_stall  = 1'b0;
    logic signed [WORD_W-1:0]    pos_x;
    logic signed [WORD_W-1:0]    pos_y;
    logic [WORD_W-1:0]           heading_angle;
    logic signed [TRIG_W-1:0]    quat_z;
    logic signed [TRIG_W-1:0]    quat_w;
    logic                        cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [WORD_W-1:0]           cfg_data   = '0;

    logic [31:0] cfg_speed = 32'h0000_8000;
    logic [31:0] cfg_rate  = 32'hFFFF_8000;
    logic [31:0] pose_x    = '0;
    logic [31:0] pose_y    = '0;
    logic [31:0] pose_hdg  = '0;

    t_pose       pose_q[$];
    int          mismatches = 0;
    int unsigned cycles     = 0;
    bit          idle_on    = 1'b1;

    unicycle_pose_integrator u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_elapsed_us    (elapsed_us),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_pos_x         (pos_x),
        .o_pos_y         (pos_y),
        .o_heading_angle (heading_angle),
        .o_quat_z        (quat_z),
        .o_quat_w        (quat_w),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32767) begin
            r = 32767;
        end else if (r < -32768) begin
            r = -32768;
        end
        return r;
    endfunction

    // binary angle, 2^32 = 2*pi
    function automatic void sin_cos_q15(input logic [31:0] ang, output longint sn,
                                        output longint cs);
        logic [31:0] a;
        logic [31:0] probe;
        logic        flip;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        a     = ang;
        probe = a + 32'h4000_0000;
        flip  = probe[31];
        if (flip) begin
            a = a - 32'h8000_0000;
        end
        z = $signed(a);
        x = ROT_GAIN;
        y = 0;
        for (int i = 0; i < ROT_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(ARCTAN[(ROT_STEPS - 1 - i) * 32 +: 32]);
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(ARCTAN[(ROT_STEPS - 1 - i) * 32 +: 32]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        sn = round_q15(y);
        cs = round_q15(x);
    endfunction

    // signed product scaled down, truncated toward zero
    function automatic logic [63:0] scale_trunc(input longint a, input logic [31:0] b,
                                                input int sh);
        logic [63:0]  mag;
        logic [127:0] prod;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = (128'(mag) * 128'(b)) >> sh;
        return (a < 0) ? -prod[63:0] : prod[63:0];
    endfunction

    function automatic logic [31:0] clamp_add(input logic [31:0] p, input longint d);
        longint v;
        v = longint'($signed(p)) + d;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return 32'(v);
    endfunction

    function automatic t_pose advance_pose(input logic [ELAPSED_W-1:0] us);
        logic [51:0] tprod;
        logic [31:0] dt;
        longint      sn;
        longint      cs;
        longint      dx;
        longint      dy;
        logic [63:0] dh;
        t_pose       r;
        tprod = 52'(us) * 52'(TICK_SCALE);
        dt    = tprod[51:20];
        sin_cos_q15({pose_hdg[30:0], 1'b0}, sn, cs);
        dx = $signed(scale_trunc(longint'($signed(cfg_speed)) * cs, dt, MOVE_SHIFT));
        dy = $signed(scale_trunc(longint'($signed(cfg_speed)) * sn, dt, MOVE_SHIFT));
        pose_x   = clamp_add(pose_x, dx);
        pose_y   = clamp_add(pose_y, dy);
        dh       = scale_trunc(longint'($signed(cfg_rate)) * longint'(dt), ANGLE_SCALE,
                               TURN_SHIFT);
        pose_hdg = pose_hdg + dh[31:0];
        sin_cos_q15(pose_hdg, sn, cs);
        r.x   = pose_x;
        r.y   = pose_y;
        r.hdg = pose_hdg;
        r.qz  = 16'(sn);
        r.qw  = 16'(cs);
        return r;
    endfunction

    function automatic logic [31:0] pick_setting();
        case ($urandom_range(0, 9)) inside
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3, 4: return $urandom;
            default: return 32'($urandom_range(0, 524288)) - 32'd262144;
        endcase
    endfunction

    function automatic logic [ELAPSED_W-1:0] pick_elapsed();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return ELAPSED_W'($urandom_range(15000, 25000));
        end else if (sel < 78) begin
            return ELAPSED_W'($urandom);
        end else if (sel < 86) begin
            return '0;
        end else if (sel < 95) begin
            return ELAPSED_W'($urandom_range(1, 100));
        end
        return '1;
    endfunction

    task automatic send_tick(input logic [ELAPSED_W-1:0] us);
        if (idle_on && $urandom_range(0, 99) < 11) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 80)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        elapsed_us <= us;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pose_q.push_back(advance_pose(us));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pose_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_motion(input logic [31:0] speed, input logic [31:0] rate);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LINEAR_SPEED;
        cfg_data  <= speed;
        @(posedge clk);
        cfg_speed = speed;
        cfg_index <= CFG_ANGULAR_RATE;
        cfg_data  <= rate;
        @(posedge clk);
        cfg_rate = rate;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_tick('0);
        send_tick(ELAPSED_W'(20000));
        send_tick(ELAPSED_W'(1));
        send_tick('1);
        send_tick(20'h55555);
        send_tick(20'hAAAAA);
        send_tick('0);
    endtask

    task automatic test_saturation_and_wrap();
        set_motion(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        repeat (3) send_tick('1);
        set_motion(32'h8000_0000, 32'h8000_0000);
        repeat (4) send_tick('1);
        set_motion('0, '0);
        send_tick('1);
        send_tick(ELAPSED_W'(12345));
    endtask

    task automatic test_heading_sweep();
        set_motion(32'h0001_0000, 32'h0003_2000);
        repeat (6) send_tick(ELAPSED_W'(500000));
    endtask

    task automatic test_random_drive();
        for (int ph = 0; ph < 10; ph++) begin
            set_motion(pick_setting(), pick_setting());
            repeat (90) send_tick(pick_elapsed());
        end
    endtask

    task automatic test_back_to_back();
        set_motion(pick_setting(), pick_setting());
        idle_on = 1'b0;
        repeat (130) send_tick(pick_elapsed());
        drain();
        idle_on = 1'b1;
    endtask

    always @(posedge clk) begin
        if (cycles >= RUN_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        cycles <= cycles + 1;
    end

    always @(posedge clk) begin : check_pose
        t_pose want;
        if (rst_n && out_valid && !out_stall) begin
            if (pose_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("unexpected result beat at cycle %0d", cycles);
                end
            end else begin
                want = pose_q.pop_front();
                if (pos_x !== want.x || pos_y !== want.y || heading_angle !== want.hdg ||
                    quat_z !== want.qz || quat_w !== want.qw) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX) begin
                        $display("mismatch at cycle %0d", cycles);
                        $display("  pos_x   exp %h got %h", want.x, pos_x);
                        $display("  pos_y   exp %h got %h", want.y, pos_y);
                        $display("  heading exp %h got %h", want.hdg, heading_angle);
                        $display("  quat_z  exp %h got %h", want.qz, quat_z);
                        $display("  quat_w  exp %h got %h", want.qw, quat_w);
                    end
                end
            end
        end
        out_stall <= idle_on && ($urandom_range(0, 99) < 11);
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_saturation_and_wrap();
        test_heading_sweep();
        test_random_drive();
        test_back_to_back();
        drain();
        repeat (BEAT_CYCLES) @(posedge clk);
        mismatches += pose_q.size();
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
